>>> sv/event_receptor_pool_core_assert.svh
// Assertion macros shared by the event receptor pool modules.
`ifndef EVENT_RECEPTOR_POOL_CORE_ASSERT_SVH
`define EVENT_RECEPTOR_POOL_CORE_ASSERT_SVH

`ifndef SYNTH
// Clocked check on clk_i, switched off while rst_ni is low.
`define ERP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("event receptor pool assertion failed");
// Clocked check on clk_i that also holds while reset is applied.
`define ERP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("event receptor pool assertion failed");
`else
`define ERP_ASSERT(lbl, prop)
`define ERP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> sv/erp_pkg.sv
// Types, codes and constants of the event receptor pool.
`default_nettype none

package erp_pkg;

  localparam int unsigned NUM_SLOTS_DEF   = 64;
  localparam int unsigned HANDLE_BITS_DEF = 32;
  localparam int unsigned SLOT_SPAN       = 64;
  localparam logic [6:0]  ACTIVE_RESET    = 7'd64;

  // Waiter word codes; any other value is the handle of a waiting thread.
  localparam int unsigned WORD_EMPTY    = 0;
  localparam int unsigned WORD_SIGNALED = 1;

  localparam logic [2:0] MODE_GET          = 3'd0;
  localparam logic [2:0] MODE_RETURN       = 3'd1;
  localparam logic [2:0] MODE_WAIT         = 3'd2;
  localparam logic [2:0] MODE_SIGNAL       = 3'd3;
  localparam logic [2:0] MODE_SIGNAL_YIELD = 3'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BLOCK  = 2'd1,
    ST_BUSY   = 2'd2,
    ST_NOFREE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  slot_index;
    logic [31:0] thread_handle;
  } op_t;

  typedef struct packed {
    status_e     status;
    logic [5:0]  granted_slot;
    logic        wake_valid;
    logic [31:0] wake_handle;
    logic        yield_request;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> sv/event_receptor_pool_core.sv
// Top level of the event receptor pool: controller and datapath.
// Usage:
// A command word (mode, slot index, thread handle) is taken on op_i at a
// rising clock edge where start is high and busy is low. Each command word
// produces exactly one result word on result_o, shown for one clock cycle
// while done_o is high. The receiver cannot hold results off, so the block
// never waits on the result side.
// done_o is high in the cycle that follows the busy cycle; the result word
// is registered into result_o at the end of the busy cycle.
// The block takes no new command word while one is in work: busy is high
// after each accept, while the waiter word of the addressed
// slot is read from the registered memory port and written back.
// A new command word may be accepted in the same cycle that a result is shown.
// The user must write the active slot count (cfg_we_i, cfg_wdata_i) only while
// the block is idle (unchecked by it); it takes effect for the next command word.
// Reset makes every slot free and every waiter word empty at once, through a
// valid flag per memory word, and sets the active count to 64. The block
// accepts commands in the first cycle after reset is released.
`default_nettype none

module event_receptor_pool_core #(
  parameter int unsigned NUM_SLOTS   = erp_pkg::NUM_SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = erp_pkg::HANDLE_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  erp_pkg::op_t  op_i,
  input  logic          cfg_we_i,
  input  logic [6:0]    cfg_wdata_i,
  output logic          done_o,
  output erp_pkg::res_t result_o
);
  import erp_pkg::*;

  // Commands from the controller to the datapath.
  ctrl_cmd_t cmd;

  erp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  // The datapath holds the slot flags, the waiter memory, the active count
  // register and the result register.
  erp_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (op_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire

>>> sv/erp_ctrl.sv
// Controller state machine of the event receptor pool.
`default_nettype none
`include "event_receptor_pool_core_assert.svh"

module erp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output erp_pkg::ctrl_cmd_t cmd_o
);
  import erp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy_o     = 1'b0;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_EXEC: begin
        busy_o     = 1'b1;
        cmd_o.exec = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  `ERP_ASSERT(a_load_then_exec, cmd_o.load |=> cmd_o.exec)
  `ERP_ASSERT(a_exec_single, cmd_o.exec |=> !cmd_o.exec)
  `ERP_ASSERT_ALWAYS(a_load_not_busy, cmd_o.load |-> !busy_o)

endmodule

`default_nettype wire

>>> sv/erp_datapath.sv
// Datapath of the event receptor pool: slot flags, waiter memory and result register.
`default_nettype none
`include "event_receptor_pool_core_assert.svh"

module erp_datapath #(
  parameter int unsigned NUM_SLOTS   = erp_pkg::NUM_SLOTS_DEF,
  parameter int unsigned HANDLE_BITS = erp_pkg::HANDLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  erp_pkg::ctrl_cmd_t cmd_i,
  input  erp_pkg::op_t       op_i,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  output logic               done_o,
  output erp_pkg::res_t      result_o
);
  import erp_pkg::*;

  // Slot indices never reach past the span of the index field.
  localparam int unsigned Depth = (NUM_SLOTS < SLOT_SPAN) ? NUM_SLOTS : SLOT_SPAN;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [6:0]  DepthCount = 7'(Depth);
  localparam logic [HANDLE_BITS-1:0] WordEmpty    = HANDLE_BITS'(WORD_EMPTY);
  localparam logic [HANDLE_BITS-1:0] WordSignaled = HANDLE_BITS'(WORD_SIGNALED);

  logic [6:0]             active_count_q;
  logic [Depth-1:0]       in_use_q, in_use_d;
  logic [Depth-1:0]       word_vld_q;
  logic [HANDLE_BITS-1:0] waiter_mem [Depth];
  logic [HANDLE_BITS-1:0] rdata_q;
  logic                   rvld_q;
  op_t                    op_q;
  res_t                   res_q, res_d;
  logic                   done_q;

  logic [6:0]             count_eff;
  logic [IdxW-1:0]        addr;
  logic [IdxW-1:0]        free_idx;
  logic                   free_found;
  logic                   in_range;
  logic [HANDLE_BITS-1:0] word;
  logic [HANDLE_BITS-1:0] hdl;
  logic                   we;
  logic [IdxW-1:0]        waddr;
  logic [HANDLE_BITS-1:0] wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
    end
  end

  // Waiter memory with one registered read port and one write port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      waiter_mem[waddr] <= wdata;
    end
    if (cmd_i.load) begin
      rdata_q <= waiter_mem[op_i.slot_index[IdxW-1:0]];
    end
  end

  // A word never written since reset reads as empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
      rvld_q     <= 1'b0;
      in_use_q   <= '0;
      done_q     <= 1'b0;
    end else begin
      if (we) word_vld_q[waddr] <= 1'b1;
      if (cmd_i.load) rvld_q <= word_vld_q[op_i.slot_index[IdxW-1:0]];
      in_use_q <= in_use_d;
      done_q   <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  assign count_eff = (active_count_q > DepthCount) ? DepthCount : active_count_q;
  assign addr      = op_q.slot_index[IdxW-1:0];
  assign in_range  = {1'b0, op_q.slot_index} < count_eff;
  assign word      = rvld_q ? rdata_q : WordEmpty;
  assign hdl       = HANDLE_BITS'(op_q.thread_handle);

  // Priority encoder: lowest free slot below the active count.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = Depth - 1; i >= 0; i--) begin
      if (!in_use_q[i] && (7'(i) < count_eff)) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  always_comb begin
    res_d         = '0;
    res_d.status  = ST_OK;
    in_use_d      = in_use_q;
    we            = 1'b0;
    waddr         = addr;
    wdata         = WordEmpty;
    if (cmd_i.exec) begin
      case (op_q.mode) inside
        MODE_GET: begin
          if (free_found) begin
            in_use_d[free_idx] = 1'b1;
            we                 = 1'b1;
            waddr              = free_idx;
            res_d.granted_slot = 6'(free_idx);
          end else begin
            res_d.status = ST_NOFREE;
          end
        end
        MODE_RETURN: begin
          if (in_range && in_use_q[addr]) begin
            in_use_d[addr] = 1'b0;
            we             = 1'b1;
          end
        end
        MODE_WAIT: begin
          if (in_range) begin
            if (word == WordSignaled) begin
              we = 1'b1;
            end else if (word != WordEmpty || hdl == WordEmpty || hdl == WordSignaled) begin
              res_d.status = ST_BUSY;
            end else begin
              we           = 1'b1;
              wdata        = hdl;
              res_d.status = ST_BLOCK;
            end
          end
        end
        MODE_SIGNAL, MODE_SIGNAL_YIELD: begin
          if (in_range) begin
            if (word == WordEmpty) begin
              we    = 1'b1;
              wdata = WordSignaled;
            end else if (word != WordSignaled) begin
              we                  = 1'b1;
              res_d.wake_valid    = 1'b1;
              res_d.wake_handle   = 32'(word);
              res_d.yield_request = (op_q.mode == MODE_SIGNAL_YIELD);
            end
          end
        end
        default: begin
          res_d.status = ST_OK;
        end
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  `ERP_ASSERT(a_exec_gives_done, cmd_i.exec |=> done_q)
  `ERP_ASSERT(a_wake_is_ok, done_q && res_q.wake_valid |-> res_q.status == ST_OK)
  `ERP_ASSERT(a_yield_needs_wake, done_q && res_q.yield_request |-> res_q.wake_valid)
  `ERP_ASSERT(a_state_only_on_exec, !cmd_i.exec |=> $stable(in_use_q))

endmodule

`default_nettype wire
